[src/spp_pkg.sv]
// Shared types and sizes for the sweep-and-prune pair finder.
// Used by spp_front, spp_back and sweep_and_prune_pairs; no dependencies.
package spp_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int PAIRS   = 64;
  localparam int PIDX_W  = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int PCNT_W  = $clog2(PAIRS + 1);

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [7:0]         body_id;
    logic signed [31:0] lo_x;
    logic signed [31:0] lo_y;
    logic signed [31:0] lo_z;
    logic signed [31:0] hi_x;
    logic signed [31:0] hi_y;
    logic signed [31:0] hi_z;
    logic [31:0]        group_bits;
    logic [31:0]        mask_bits;
    logic [31:0]        compound_tag;
    logic               final_box;
  } in_t;

  typedef struct packed {
    logic [7:0] first_body;
    logic [7:0] second_body;
    logic       pair_valid;
    logic       overflowed;
    logic       run_end;
  } out_t;

  // stored box; lo/hi indexed by axis code
  typedef struct packed {
    logic [7:0]       body;
    logic [2:0][31:0] lo;
    logic [2:0][31:0] hi;
    logic [31:0]      group;
    logic [31:0]      mask;
    logic [31:0]      comp;
  } rec_t;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] second;
  } pair_t;

  // front to back: pair write port and end of sweep
  typedef struct packed {
    logic              wr_en;
    logic [PIDX_W-1:0] wr_addr;
    pair_t             wr_data;
    logic              done;
    logic [PCNT_W-1:0] count;
    logic              ovf;
  } sweep_t;

endpackage

[src/spp_front.sv]
// Front end: box store, scene bounds, axis choice, rank sort and pair sweep.
// Depends on spp_pkg; feeds pairs to spp_back through spp_pkg::sweep_t.
module spp_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_acc,
  input  spp_pkg::in_t    in_data,
  input  logic            back_idle,
  output logic            busy,
  output spp_pkg::sweep_t sw
);

  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_AXIS  = 4'd1;
  localparam logic [3:0] S_RK_I  = 4'd2;
  localparam logic [3:0] S_RK_IW = 4'd3;
  localparam logic [3:0] S_RK_J  = 4'd4;
  localparam logic [3:0] S_RK_JW = 4'd5;
  localparam logic [3:0] S_WAIT  = 4'd6;
  localparam logic [3:0] S_A     = 4'd7;
  localparam logic [3:0] S_AW    = 4'd8;
  localparam logic [3:0] S_AR    = 4'd9;
  localparam logic [3:0] S_B     = 4'd10;
  localparam logic [3:0] S_BW    = 4'd11;
  localparam logic [3:0] S_BR    = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  spp_pkg::rec_t rec_mem [spp_pkg::ENTRIES];
  logic [spp_pkg::IDX_W-1:0] ord_mem [spp_pkg::ENTRIES];

  logic [3:0] st_r, st_nxt;
  logic [spp_pkg::CNT_W-1:0] cnt_r, cnt_nxt, n_r, n_nxt;
  logic [spp_pkg::CNT_W-1:0] i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic [spp_pkg::PCNT_W-1:0] pcnt_r, pcnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [1:0] axis_r, axis_nxt;
  logic [2:0][31:0] slo_r, slo_nxt, shi_r, shi_nxt;
  logic [31:0] key_r, key_nxt;
  spp_pkg::rec_t a_r, a_nxt;

  spp_pkg::rec_t rd_q, wr_rec;
  logic [spp_pkg::IDX_W-1:0] rd_addr, ord_addr, ord_q, ord_waddr, ord_wdata;
  logic rec_we, ord_we;
  logic signed [32:0] ext_x, ext_y, ext_z;
  logic [31:0] kj;
  logic [spp_pkg::CNT_W-1:0] rank_new;
  logic touch, filt;

  always_comb begin
    wr_rec.body  = in_data.body_id;
    wr_rec.lo    = {in_data.lo_z, in_data.lo_y, in_data.lo_x};
    wr_rec.hi    = {in_data.hi_z, in_data.hi_y, in_data.hi_x};
    wr_rec.group = in_data.group_bits;
    wr_rec.mask  = in_data.mask_bits;
    wr_rec.comp  = in_data.compound_tag;
  end

  assign ext_x = $signed({shi_r[0][31], shi_r[0]}) - $signed({slo_r[0][31], slo_r[0]});
  assign ext_y = $signed({shi_r[1][31], shi_r[1]}) - $signed({slo_r[1][31], slo_r[1]});
  assign ext_z = $signed({shi_r[2][31], shi_r[2]}) - $signed({slo_r[2][31], slo_r[2]});

  assign kj = rd_q.lo[axis_r];
  always_comb begin
    rank_new = rank_r;
    if ($signed(kj) < $signed(key_r) || (kj == key_r && j_r < i_r)) begin
      rank_new = rank_r + 1'b1;
    end
  end

  always_comb begin
    touch = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if ($signed(a_r.lo[k]) > $signed(rd_q.hi[k])) touch = 1'b0;
      if ($signed(rd_q.lo[k]) > $signed(a_r.hi[k])) touch = 1'b0;
    end
    filt = (a_r.comp != 32'd0 && a_r.comp == rd_q.comp) ||
           ((a_r.group & rd_q.mask) == 32'd0) || ((rd_q.group & a_r.mask) == 32'd0);
  end

  always_comb begin
    st_nxt   = st_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    i_nxt    = i_r;
    j_nxt    = j_r;
    rank_nxt = rank_r;
    pcnt_nxt = pcnt_r;
    ovf_nxt  = ovf_r;
    axis_nxt = axis_r;
    slo_nxt  = slo_r;
    shi_nxt  = shi_r;
    key_nxt  = key_r;
    a_nxt    = a_r;
    rec_we   = 1'b0;
    ord_we   = 1'b0;
    ord_waddr = rank_new[spp_pkg::IDX_W-1:0];
    ord_wdata = i_r[spp_pkg::IDX_W-1:0];
    rd_addr  = ord_q;
    ord_addr = i_r[spp_pkg::IDX_W-1:0];
    sw         = '0;
    sw.wr_addr = pcnt_r[spp_pkg::PIDX_W-1:0];
    sw.wr_data.first  = a_r.body;
    sw.wr_data.second = rd_q.body;
    sw.count   = pcnt_r;
    sw.ovf     = ovf_r;
    case (st_r)
      S_LOAD: begin
        rd_addr = cnt_r[spp_pkg::IDX_W-1:0];
        if (in_acc) begin
          if (cnt_r < spp_pkg::CNT_W'(spp_pkg::ENTRIES)) begin
            rec_we  = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            for (int k = 0; k < 3; k++) begin
              if ($signed(wr_rec.lo[k]) < $signed(slo_r[k])) slo_nxt[k] = wr_rec.lo[k];
              if ($signed(wr_rec.hi[k]) > $signed(shi_r[k])) shi_nxt[k] = wr_rec.hi[k];
            end
          end
          if (in_data.final_box) begin
            n_nxt  = cnt_nxt;
            st_nxt = S_AXIS;
          end
        end
      end
      S_AXIS: begin
        if (ext_y > ext_x && ext_y > ext_z) axis_nxt = spp_pkg::AXIS_Y;
        else if (ext_z > ext_x) axis_nxt = spp_pkg::AXIS_Z;
        else axis_nxt = spp_pkg::AXIS_X;
        // drop the frame bounds; the boxes stay in the store
        cnt_nxt = '0;
        for (int k = 0; k < 3; k++) begin
          slo_nxt[k] = 32'h7fff_ffff;
          shi_nxt[k] = 32'h8000_0000;
        end
        i_nxt  = '0;
        st_nxt = S_RK_I;
      end
      S_RK_I: begin
        rd_addr = i_r[spp_pkg::IDX_W-1:0];
        st_nxt  = S_RK_IW;
      end
      S_RK_IW: begin
        key_nxt  = rd_q.lo[axis_r];
        j_nxt    = '0;
        rank_nxt = '0;
        st_nxt   = S_RK_J;
      end
      S_RK_J: begin
        rd_addr = j_r[spp_pkg::IDX_W-1:0];
        st_nxt  = S_RK_JW;
      end
      S_RK_JW: begin
        rank_nxt = rank_new;
        if (j_r == n_r - 1'b1) begin
          ord_we = 1'b1;
          if (i_r == n_r - 1'b1) begin
            st_nxt = S_WAIT;
          end else begin
            i_nxt  = i_r + 1'b1;
            st_nxt = S_RK_I;
          end
        end else begin
          j_nxt  = j_r + 1'b1;
          st_nxt = S_RK_J;
        end
      end
      S_WAIT: begin
        // hold until the previous frame's pairs are all out
        if (back_idle) begin
          i_nxt    = '0;
          pcnt_nxt = '0;
          ovf_nxt  = 1'b0;
          st_nxt   = S_A;
        end
      end
      S_A: st_nxt = S_AW;
      S_AW: st_nxt = S_AR;
      S_AR: begin
        a_nxt = rd_q;
        j_nxt = i_r + 1'b1;
        if (i_r + 1'b1 >= n_r) st_nxt = S_DONE;
        else st_nxt = S_B;
      end
      S_B: begin
        ord_addr = j_r[spp_pkg::IDX_W-1:0];
        st_nxt   = S_BW;
      end
      S_BW: st_nxt = S_BR;
      S_BR: begin
        if ($signed(rd_q.lo[axis_r]) > $signed(a_r.hi[axis_r])) begin
          i_nxt  = i_r + 1'b1;
          st_nxt = S_A;
        end else begin
          if (touch && !filt) begin
            if (pcnt_r < spp_pkg::PCNT_W'(spp_pkg::PAIRS)) begin
              sw.wr_en = 1'b1;
              pcnt_nxt = pcnt_r + 1'b1;
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (j_r + 1'b1 == n_r) begin
            i_nxt  = i_r + 1'b1;
            st_nxt = S_A;
          end else begin
            j_nxt  = j_r + 1'b1;
            st_nxt = S_B;
          end
        end
      end
      S_DONE: begin
        sw.done = 1'b1;
        st_nxt  = S_LOAD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  assign busy = (st_r != S_LOAD);

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[cnt_r[spp_pkg::IDX_W-1:0]] <= wr_rec;
    rd_q <= rec_mem[rd_addr];
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_q <= ord_mem[ord_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_LOAD;
      cnt_r  <= '0;
      pcnt_r <= '0;
      ovf_r  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        slo_r[k] <= 32'h7fff_ffff;
        shi_r[k] <= 32'h8000_0000;
      end
    end else begin
      st_r   <= st_nxt;
      cnt_r  <= cnt_nxt;
      pcnt_r <= pcnt_nxt;
      ovf_r  <= ovf_nxt;
      slo_r  <= slo_nxt;
      shi_r  <= shi_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    i_r    <= i_nxt;
    j_r    <= j_nxt;
    rank_r <= rank_nxt;
    axis_r <= axis_nxt;
    key_r  <= key_nxt;
    a_r    <= a_nxt;
  end

endmodule

[src/spp_back.sv]
// Back end: pair buffer and result sequencer with overflow and end marks.
// Depends on spp_pkg; fed by spp_front through spp_pkg::sweep_t.
module spp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  spp_pkg::sweep_t sw,
  output logic            idle,
  output logic            out_valid,
  output spp_pkg::out_t   out_data
);

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_RD    = 2'd1;
  localparam logic [1:0] B_OUT   = 2'd2;
  localparam logic [1:0] B_EMPTY = 2'd3;

  spp_pkg::pair_t pair_mem [spp_pkg::PAIRS];
  spp_pkg::pair_t rd_q;

  logic [1:0] st_r, st_nxt;
  logic [spp_pkg::PCNT_W-1:0] cnt_r, cnt_nxt, k_r, k_nxt;
  logic ovf_r, ovf_nxt;
  logic last;

  assign last = (k_r + 1'b1 == cnt_r);

  always_comb begin
    st_nxt  = st_r;
    cnt_nxt = cnt_r;
    k_nxt   = k_r;
    ovf_nxt = ovf_r;
    case (st_r)
      B_IDLE: begin
        if (sw.done) begin
          cnt_nxt = sw.count;
          ovf_nxt = sw.ovf;
          k_nxt   = '0;
          st_nxt  = (sw.count == '0) ? B_EMPTY : B_RD;
        end
      end
      B_RD: st_nxt = B_OUT;
      B_OUT: begin
        k_nxt  = k_r + 1'b1;
        st_nxt = last ? B_IDLE : B_RD;
      end
      B_EMPTY: st_nxt = B_IDLE;
      default: st_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid = (st_r == B_OUT) || (st_r == B_EMPTY);
    out_data  = '0;
    if (st_r == B_OUT) begin
      out_data.first_body  = rd_q.first;
      out_data.second_body = rd_q.second;
      out_data.pair_valid  = 1'b1;
      out_data.overflowed  = ovf_r;
      out_data.run_end     = last;
    end else if (st_r == B_EMPTY) begin
      out_data.run_end = 1'b1;
    end
  end

  assign idle = (st_r == B_IDLE);

  always_ff @(posedge clk) begin
    if (sw.wr_en) pair_mem[sw.wr_addr] <= sw.wr_data;
    rd_q <= pair_mem[k_r[spp_pkg::PIDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= B_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    cnt_r <= cnt_nxt;
    k_r   <= k_nxt;
    ovf_r <= ovf_nxt;
  end

  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (idle && sw.done) |=> !idle)
    else $error("sweep end did not start the result run");

  a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !(sw.done && !idle))
    else $error("sweep finished while results still pending");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.run_end) |=> idle)
    else $error("run end not followed by idle");

  a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.pair_valid) |-> (out_data.run_end && !out_data.overflowed))
    else $error("empty marker malformed");

endmodule

[src/sweep_and_prune_pairs.sv]
// Top level of the sweep-and-prune pair finder.
// Depends on spp_pkg, spp_front and spp_back.
//
//   channel  ports                      handshake
//   input    start, busy, in_data       taken when start && !busy
//   result   out_valid, out_data        one-cycle strobe, never held off
//
// A non-final box is stored. The final box starts the frame run: the axis
// choice, a rank sort over the box store read port, then the sweep, which waits
// for the previous frame's results to drain and then visits each row and pair.
// Results leave the pair buffer while the next frame loads; each is read first.
// busy stays high from the final box until the sweep ends; reset is synchronous.
module sweep_and_prune_pairs (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spp_pkg::in_t  in_data,
  output logic          out_valid,
  output spp_pkg::out_t out_data
);

  spp_pkg::sweep_t sw;
  logic back_idle;

  spp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (start && !busy),
    .in_data   (in_data),
    .back_idle (back_idle),
    .busy      (busy),
    .sw        (sw)
  );

  spp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .sw        (sw),
    .idle      (back_idle),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
